/* hdl/ssrc_pkg.sv */
// ----------------------------------------------------------------------------
// ssrc_pkg - shared types and constants of the speed ramp controller
// Beat formats, configuration register map, command and mode codes, and
// the fixed-point constants of the smoothstep ramp and speed integrator.
// ----------------------------------------------------------------------------
package ssrc_pkg;

    // Fixed-point constants
    localparam int PROG_ONE       = 65536;  // ramp progress 1.0 in Q1.16
    localparam int DRAG_Q16       = 6553;   // coast drag 0.1 in Q0.16
    localparam int GEAR_THRESHOLD = 142;    // 2/3.6 m/s in Q8.8, truncated
    localparam int SNAP_LIMIT     = 25;     // largest speed with 10*v below 256

    // Bit-serial multiplier geometry
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 18;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRAKE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EMERGENCY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RAMP_INV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_RAMP_INV = 3'd5;

    localparam logic [14:0] RST_MAX_ACCEL      = 15'd768;
    localparam logic [14:0] RST_MAX_BRAKE      = 15'd1536;
    localparam logic [14:0] RST_MAX_EMERGENCY  = 15'd2304;
    localparam logic [15:0] RST_MAX_SPEED      = 16'd7111;
    localparam logic [15:0] RST_ACCEL_RAMP_INV = 16'd256;
    localparam logic [15:0] RST_BRAKE_RAMP_INV = 16'd512;

    // Command codes
    localparam logic [1:0] REQ_TRACK     = 2'd0;
    localparam logic [1:0] REQ_EMERGENCY = 2'd1;
    localparam logic [1:0] REQ_HOLD      = 2'd2;
    localparam logic [1:0] REQ_GEAR      = 2'd3;

    // Ramp mode codes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ACCEL = 2'd1;
    localparam logic [1:0] MODE_BRAKE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] desired_speed;
        logic [15:0]        tick_time;
    } t_in_beat;

    typedef struct packed {
        logic [15:0]        speed;
        logic signed [15:0] acceleration;
        logic [1:0]         accel_mode;
        logic               reverse_gear;
    } t_out_beat;

    typedef struct packed {
        logic [14:0] max_accel;
        logic [14:0] max_brake;
        logic [14:0] max_emergency_brake;
        logic [15:0] max_speed;
        logic [15:0] accel_ramp_inverse;
        logic [15:0] brake_ramp_inverse;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] p;
    } t_mul_rsp;

endpackage

/* hdl/ssrc_regs.sv */
// ----------------------------------------------------------------------------
// ssrc_regs - configuration register file
// Six limit and ramp registers, written one beat at a time; unknown indexes
// are dropped and data bits above a register's width are discarded.
// ----------------------------------------------------------------------------
module ssrc_regs
    import ssrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Always take a write beat
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Store written values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_accel           <= RST_MAX_ACCEL;
            r_cfg.max_brake           <= RST_MAX_BRAKE;
            r_cfg.max_emergency_brake <= RST_MAX_EMERGENCY;
            r_cfg.max_speed           <= RST_MAX_SPEED;
            r_cfg.accel_ramp_inverse  <= RST_ACCEL_RAMP_INV;
            r_cfg.brake_ramp_inverse  <= RST_BRAKE_RAMP_INV;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_ACCEL:      r_cfg.max_accel           <= i_cfg_data[14:0];
                CFG_MAX_BRAKE:      r_cfg.max_brake           <= i_cfg_data[14:0];
                CFG_MAX_EMERGENCY:  r_cfg.max_emergency_brake <= i_cfg_data[14:0];
                CFG_MAX_SPEED:      r_cfg.max_speed           <= i_cfg_data;
                CFG_ACCEL_RAMP_INV: r_cfg.accel_ramp_inverse  <= i_cfg_data;
                CFG_BRAKE_RAMP_INV: r_cfg.brake_ramp_inverse  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* hdl/ssrc_mul.sv */
// ----------------------------------------------------------------------------
// ssrc_mul - bit-serial shift-and-add multiplier
// Retires one multiplier bit per cycle, LSB first; the partial product
// shifts right so only one multiplicand-wide adder is needed.
// ----------------------------------------------------------------------------
module ssrc_mul
    import ssrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_A_W-1:0]   r_hi;
    logic [MUL_B_W-1:0]   r_lo;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MUL_A_W:0]     sum;

    // Add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, r_hi} + (r_b[0] ? {1'b0, r_a} : '0);

    assign o_rsp.done = r_done;
    assign o_rsp.p    = {r_hi, r_lo};

    // Control: busy for one cycle per multiplier bit, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_B_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_b  <= i_req.b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_b  <= {1'b0, r_b[MUL_B_W-1:1]};
            r_hi <= sum[MUL_A_W:1];
            r_lo <= {sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

endmodule

/* hdl/smoothstep_speed_ramp_controller_core.sv */
// ----------------------------------------------------------------------------
// smoothstep_speed_ramp_controller_core - S-curve speed ramp controller
// Input beat: command, desired speed and tick length. Output beat: updated
// speed, commanded acceleration, ramp mode and reverse gear flag, one per
// input beat. Configuration beats load the six limit and ramp registers and
// are taken in any cycle; write them only while no beat is in flight.
// Every multiply runs through one bit-serial multiplier, and one beat is
// worked at a time. A ramping track beat takes four passes (progress,
// square, smoothstep, scale) and one for the speed delta, or two drag
// passes in place of the delta when the ramp acceleration comes out zero.
// A coasting track beat takes two passes; hold, gear and emergency beats
// take one or two. The next input beat is accepted the cycle after a
// result is registered.
// The result sits in an output register; the next input beat is accepted
// while it waits, and the block stalls only when a second result is ready
// before the first is taken. Reset clears speed, acceleration, ramp and gear
// state and restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module smoothstep_speed_ramp_controller_core
    import ssrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_PROG, S_SQUARE, S_SMOOTH, S_MAG,
        S_INTEG, S_DRAG_RATE, S_DRAG, S_DELTA, S_FINISH
    } t_state;

    t_state             r_state;
    t_in_beat           r_item;
    logic [15:0]        r_speed;
    logic signed [15:0] r_accel;
    logic [1:0]         r_mode;
    logic [16:0]        r_prog;
    logic               r_rev;
    logic signed [17:0] r_v;
    logic               r_out_valid;
    t_out_beat          r_out;
    t_mul_req           r_mreq;

    t_cfg               cfg;
    t_mul_rsp           mul_rsp;

    logic [1:0]         target;
    logic [24:0]        prog_sum;
    logic [16:0]        prog_next;
    logic [15:0]        accel_abs;
    logic [15:0]        coast_v;
    logic signed [17:0] delta_v;
    logic [15:0]        speed_clamped;
    logic               out_free;

    ssrc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ssrc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_rsp   (mul_rsp)
    );

    // Pick the ramp direction from desired versus current speed
    always_comb begin
        if (r_item.desired_speed > $signed({1'b0, r_speed})) begin
            target = MODE_ACCEL;
        end else if (r_item.desired_speed < $signed({1'b0, r_speed})) begin
            target = MODE_BRAKE;
        end else begin
            target = MODE_NONE;
        end
    end

    // Advance ramp progress, saturating at one
    assign prog_sum  = {8'b0, r_prog} + {1'b0, mul_rsp.p[31:8]};
    assign prog_next = (prog_sum > 25'(PROG_ONE)) ? 17'(PROG_ONE) : prog_sum[16:0];

    // Integrator helpers
    assign accel_abs = r_accel[15] ? 16'(-r_accel) : 16'(r_accel);
    assign coast_v   = r_speed - mul_rsp.p[47:32];
    assign delta_v   = r_accel[15] ?
                       $signed({2'b0, r_speed}) - $signed({3'b0, mul_rsp.p[30:16]}) :
                       $signed({2'b0, r_speed}) + $signed({3'b0, mul_rsp.p[30:16]});

    // Clamp the new speed to zero and the ceiling
    always_comb begin
        if (r_v[17]) begin
            speed_clamped = '0;
        end else if (r_v[16:0] > {1'b0, cfg.max_speed}) begin
            speed_clamped = cfg.max_speed;
        end else begin
            speed_clamped = r_v[15:0];
        end
    end

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer: state, ramp state, multiplier requests and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= '0;
            r_accel     <= '0;
            r_mode      <= MODE_NONE;
            r_prog      <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
            r_mreq.start <= 1'b0;
        end else begin
            r_mreq.start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_state <= S_INTEG;
                    case (r_item.req_type)
                        REQ_TRACK: begin
                            if (target != r_mode) begin
                                r_mode <= target;
                                r_prog <= '0;
                            end
                            if (target == MODE_NONE) begin
                                r_accel <= '0;
                            end else begin
                                r_mreq.start <= 1'b1;
                                r_mreq.a     <= {16'b0, r_item.tick_time};
                                r_mreq.b     <= (target == MODE_ACCEL) ?
                                                {2'b0, cfg.accel_ramp_inverse} :
                                                {2'b0, cfg.brake_ramp_inverse};
                                r_state      <= S_PROG;
                            end
                        end
                        REQ_EMERGENCY: begin
                            r_accel <= -$signed({1'b0, cfg.max_emergency_brake});
                            r_mode  <= MODE_BRAKE;
                            r_prog  <= '0;
                        end
                        REQ_GEAR: begin
                            if (r_speed <= 16'(GEAR_THRESHOLD)) begin
                                r_rev <= ~r_rev;
                            end
                        end
                        default: ;
                    endcase
                end
                S_PROG: begin
                    if (mul_rsp.done) begin
                        r_prog       <= prog_next;
                        r_mreq.start <= 1'b1;
                        r_mreq.a     <= {15'b0, prog_next};
                        r_mreq.b     <= {1'b0, prog_next};
                        r_state      <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    // t2 times (3 - 2t)
                    if (mul_rsp.done) begin
                        r_mreq.start <= 1'b1;
                        r_mreq.a     <= {15'b0, mul_rsp.p[32:16]};
                        r_mreq.b     <= 18'(3 * PROG_ONE) - {r_prog, 1'b0};
                        r_state      <= S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    // Scale smoothstep by the active limit
                    if (mul_rsp.done) begin
                        r_mreq.start <= 1'b1;
                        r_mreq.a     <= {15'b0, mul_rsp.p[32:16]};
                        r_mreq.b     <= (r_mode == MODE_ACCEL) ? {3'b0, cfg.max_accel} :
                                                                 {3'b0, cfg.max_brake};
                        r_state      <= S_MAG;
                    end
                end
                S_MAG: begin
                    if (mul_rsp.done) begin
                        r_accel <= (r_mode == MODE_ACCEL) ?
                                   $signed({1'b0, mul_rsp.p[30:16]}) :
                                   -$signed({1'b0, mul_rsp.p[30:16]});
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    r_mreq.start <= 1'b1;
                    if (r_accel == '0) begin
                        r_mreq.a <= {16'b0, r_speed};
                        r_mreq.b <= {2'b0, r_item.tick_time};
                        r_state  <= S_DRAG_RATE;
                    end else begin
                        r_mreq.a <= {16'b0, accel_abs};
                        r_mreq.b <= {2'b0, r_item.tick_time};
                        r_state  <= S_DELTA;
                    end
                end
                S_DRAG_RATE: begin
                    if (mul_rsp.done) begin
                        r_mreq.start <= 1'b1;
                        r_mreq.a     <= mul_rsp.p[31:0];
                        r_mreq.b     <= 18'(DRAG_Q16);
                        r_state      <= S_DRAG;
                    end
                end
                S_DRAG: begin
                    // Coast with drag, snap to zero near standstill
                    if (mul_rsp.done) begin
                        r_v     <= (coast_v <= 16'(SNAP_LIMIT)) ? '0 : $signed({2'b0, coast_v});
                        r_state <= S_FINISH;
                    end
                end
                S_DELTA: begin
                    if (mul_rsp.done) begin
                        r_v     <= delta_v;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // Hold until the output register can take the beat
                    if (out_free) begin
                        r_speed            <= speed_clamped;
                        r_out.speed        <= speed_clamped;
                        r_out.acceleration <= r_accel;
                        r_out.accel_mode   <= r_mode;
                        r_out.reverse_gear <= r_rev;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
